### rtl/core/spq_pkg.sv
package spq_pkg;

	localparam int DEPTH         = 64;
	localparam int KEY_WIDTH     = 32;
	localparam int PAYLOAD_WIDTH = 32;

	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int RES_KEY_W = 32;
	localparam int RES_PAY_W = 32;
	localparam int OCC_W     = 7;
	localparam int ERR_W     = 2;

	// Operation codes carried in the func field.
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	// Error codes returned in the error field.
	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

	typedef struct packed {
		logic                            func;
		logic signed [KEY_WIDTH-1:0]     key;
		logic        [PAYLOAD_WIDTH-1:0] payload;
	} spq_req_t;

	typedef struct packed {
		logic                        out_valid;
		logic signed [RES_KEY_W-1:0] out_key;
		logic        [RES_PAY_W-1:0] out_payload;
		logic        [ERR_W-1:0]     error;
		logic        [OCC_W-1:0]     occupancy;
	} spq_rsp_t;

	typedef struct packed {
		logic signed [KEY_WIDTH-1:0]     key;
		logic        [PAYLOAD_WIDTH-1:0] payload;
	} spq_entry_t;

	// Broadcast to every cell: what happens this cycle and the entry to insert.
	typedef struct packed {
		logic       ins;
		logic       rem;
		spq_entry_t new_entry;
	} spq_ctl_t;

endpackage

### rtl/core/spq_cell.sv
module spq_cell import spq_pkg::*; (
	input  logic       clk,
	input  spq_ctl_t   ctl,
	input  logic       occ,
	input  logic       prev_stays,
	input  spq_entry_t prev,
	input  spq_entry_t next,
	output logic       stays,
	output spq_entry_t entry
);

	spq_entry_t entry_q;
	spq_entry_t entry_d;

	// The stored entry stays put on an insert when it is occupied and its key is
	// not below the new key, which keeps equal keys in arrival order.
	assign stays = occ && ($signed(entry_q.key) >= $signed(ctl.new_entry.key));
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		if (ctl.rem) begin
			entry_d = next;
		end else if (ctl.ins && !stays) begin
			entry_d = prev_stays ? ctl.new_entry : prev;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

### rtl/core/sorted_priority_queue_top.sv
// Channel   Ports              Handshake                 Moves
// -------   ----------------   -----------------------   --------------------------
// request   start, busy, req   start & !busy at the edge  func, key, payload
// result    done, res          done for one cycle         valid, key, payload, error,
//                                                         occupancy
//
// For every transaction the cell row updates at the accepting edge and the
// result is on res, marked by done, in the following cycle.
// A new request may be accepted at every edge, so busy is always low; the
// rate is set by the compare and shift in the cell row.
// Reset clears the entry count and the done strobe; the cells hold no reset.
// The receiver cannot stall, so each result is shown exactly once.
module sorted_priority_queue_top import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  spq_req_t req,
	output logic     done,
	output spq_rsp_t res
);

	// The queue is a row of cells sorted by key, largest first. An insert lets
	// each cell decide locally whether it keeps its entry, takes the new one, or
	// takes its left neighbor's entry. A remove shifts every cell one place left.

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             done_q;
	spq_rsp_t         res_q;
	spq_rsp_t         res_d;
	spq_ctl_t         ctl;
	logic             accept;
	logic             is_full;
	logic             is_empty;

	spq_entry_t       cell_entry [DEPTH];
	logic [DEPTH-1:0] cell_stays;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);

	assign ctl.ins               = accept && (req.func == FUNC_INSERT) && !is_full;
	assign ctl.rem               = accept && (req.func == FUNC_REMOVE) && !is_empty;
	assign ctl.new_entry.key     = req.key;
	assign ctl.new_entry.payload = req.payload;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic       occ;
		logic       prev_stays;
		spq_entry_t prev;
		spq_entry_t next;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			// The head cell has nothing to its left: it takes the new entry
			// whenever its own entry does not stay.
			assign prev_stays = 1'b1;
			assign prev       = ctl.new_entry;
		end else begin : g_body
			assign prev_stays = cell_stays[i-1];
			assign prev       = cell_entry[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next = cell_entry[i];
		end else begin : g_inner
			assign next = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occ        (occ),
			.prev_stays (prev_stays),
			.prev       (prev),
			.next       (next),
			.stays      (cell_stays[i]),
			.entry      (cell_entry[i])
		);
	end

	always_comb begin
		count_d = count_q;
		if (ctl.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctl.rem) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	// The removed entry is read from the head cell before the shift takes effect.
	always_comb begin
		res_d.out_valid   = ctl.rem;
		res_d.out_key     = '0;
		res_d.out_payload = '0;
		res_d.error       = ERR_OK;
		res_d.occupancy   = OCC_W'(count_d);
		if (ctl.rem) begin
			res_d.out_key     = RES_KEY_W'($unsigned(cell_entry[0].key));
			res_d.out_payload = RES_PAY_W'(cell_entry[0].payload);
		end
		if (accept && (req.func == FUNC_INSERT) && is_full) begin
			res_d.error = ERR_FULL;
		end else if (accept && (req.func == FUNC_REMOVE) && is_empty) begin
			res_d.error = ERR_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign done = done_q;
	assign res  = res_q;

	// The entry count never passes the depth of the cell row.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds depth");

	// Every accepted request produces a result in the next cycle.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted request gave no result");

	// A returned entry never comes with an error code.
	a_valid_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.out_valid) |-> (res.error == ERR_OK))
		else $error("returned entry flagged with an error");

	// A dropped insert reports a full queue and leaves the count unchanged.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (res.error == ERR_FULL)) |-> (count_q == CNT_W'(DEPTH)))
		else $error("full error while the queue was not full");

endmodule
